/* rtl/core/mra_pkg.sv */
// Shared types, field widths and request kind codes for the matrix row ALU.
package mra_pkg;

	localparam int NCOLS         = 4;
	localparam int NENTRIES      = NCOLS * NCOLS;
	localparam int ELEM_W        = 32;
	localparam int ROW_W         = 2;
	localparam int KIND_W        = 3;
	localparam int PROD_W        = 2 * ELEM_W;
	localparam int ADDSUB_W      = ELEM_W + 1;
	localparam int SUM_W         = PROD_W + 2;
	localparam int FRAC_BITS_DEF = 16;

	localparam int IN_FIELDS_W   = ROW_W + (NCOLS + 1) * ELEM_W;
	localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W  = ROW_W + NCOLS * ELEM_W;
	localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef logic signed [ELEM_W-1:0]   elem_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ADDSUB_W-1:0] addsub_t;

	localparam elem_t ELEM_MAX = 32'sh7fff_ffff;
	localparam elem_t ELEM_MIN = 32'sh8000_0000;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD  = 3'd0,
		KIND_MUL   = 3'd1,
		KIND_ADD   = 3'd2,
		KIND_SUB   = 3'd3,
		KIND_SCALE = 3'd4
	} kind_t;

	typedef struct packed {
		logic             has_result;
		logic             is_addsub;
		logic [ROW_W-1:0] row;
	} ctl_t;

endpackage

/* rtl/core/mra_matrix_store.sv */
// Storage for the 4x4 right-hand matrix, written one row at a time.
module mra_matrix_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [mra_pkg::ROW_W-1:0]  wrow,
	input  mra_pkg::elem_t             wdata [mra_pkg::NCOLS],
	output mra_pkg::elem_t             mat   [mra_pkg::NENTRIES]
);

	mra_pkg::elem_t mat_q [mra_pkg::NENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int c = 0; c < mra_pkg::NCOLS; c++) begin
				mat_q[{wrow, 2'(c)}] <= wdata[c];
			end
		end
	end

	assign mat = mat_q;

endmodule

/* rtl/core/mra_product.sv */
// First compute stage: the sixteen products and the row add or subtract.
module mra_product (
	input  mra_pkg::kind_t             kind,
	input  logic [mra_pkg::ROW_W-1:0]  row,
	input  mra_pkg::elem_t             elem  [mra_pkg::NCOLS],
	input  mra_pkg::elem_t             scale_factor,
	input  mra_pkg::elem_t             mat   [mra_pkg::NENTRIES],
	output mra_pkg::prod_t             prod  [mra_pkg::NCOLS][mra_pkg::NCOLS],
	output mra_pkg::addsub_t           addsub [mra_pkg::NCOLS],
	output mra_pkg::ctl_t              ctl
);

	logic is_scale;
	logic is_sub;

	always_comb begin
		ctl.row        = row;
		ctl.has_result = 1'b0;
		ctl.is_addsub  = 1'b0;
		is_scale       = 1'b0;
		is_sub         = 1'b0;
		unique case (kind)
			mra_pkg::KIND_LOAD: begin
			end
			mra_pkg::KIND_MUL: begin
				ctl.has_result = 1'b1;
			end
			mra_pkg::KIND_ADD: begin
				ctl.has_result = 1'b1;
				ctl.is_addsub  = 1'b1;
			end
			mra_pkg::KIND_SUB: begin
				ctl.has_result = 1'b1;
				ctl.is_addsub  = 1'b1;
				is_sub         = 1'b1;
			end
			mra_pkg::KIND_SCALE: begin
				ctl.has_result = 1'b1;
				is_scale       = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// In scale mode only the first product of each column is used.
	always_comb begin
		for (int c = 0; c < mra_pkg::NCOLS; c++) begin
			for (int k = 0; k < mra_pkg::NCOLS; k++) begin
				if (is_scale) begin
					prod[c][k] = (k == 0) ? mra_pkg::prod_t'(elem[c] * scale_factor)
					                      : '0;
				end else begin
					prod[c][k] = mra_pkg::prod_t'(elem[k] * mat[k * mra_pkg::NCOLS + c]);
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < mra_pkg::NCOLS; c++) begin
			if (is_sub) begin
				addsub[c] = mra_pkg::addsub_t'(elem[c]) -
				            mra_pkg::addsub_t'(mat[{row, 2'(c)}]);
			end else begin
				addsub[c] = mra_pkg::addsub_t'(elem[c]) +
				            mra_pkg::addsub_t'(mat[{row, 2'(c)}]);
			end
		end
	end

endmodule

/* rtl/core/mra_reduce.sv */
// Second compute stage: sum of products with the fraction shift, or the row add or subtract result, then saturation.
module mra_reduce #(
	parameter int FRAC_BITS = mra_pkg::FRAC_BITS_DEF
) (
	input  mra_pkg::prod_t    prod   [mra_pkg::NCOLS][mra_pkg::NCOLS],
	input  mra_pkg::addsub_t  addsub [mra_pkg::NCOLS],
	input  logic              is_addsub,
	output mra_pkg::elem_t    res    [mra_pkg::NCOLS],
	output logic              overflow
);

	localparam int SUM_W = mra_pkg::SUM_W;
	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(mra_pkg::ELEM_MAX);
	localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(mra_pkg::ELEM_MIN);

	logic signed [SUM_W-1:0] sum [mra_pkg::NCOLS];
	logic signed [SUM_W-1:0] val [mra_pkg::NCOLS];
	logic [mra_pkg::NCOLS-1:0] sat;

	always_comb begin
		for (int c = 0; c < mra_pkg::NCOLS; c++) begin
			sum[c] = SUM_W'(prod[c][0]) + SUM_W'(prod[c][1]) +
			         SUM_W'(prod[c][2]) + SUM_W'(prod[c][3]);
			val[c] = is_addsub ? SUM_W'(addsub[c]) : (sum[c] >>> FRAC_BITS);
			if (val[c] > SAT_MAX) begin
				res[c] = mra_pkg::ELEM_MAX;
				sat[c] = 1'b1;
			end else if (val[c] < SAT_MIN) begin
				res[c] = mra_pkg::ELEM_MIN;
				sat[c] = 1'b1;
			end else begin
				res[c] = val[c][mra_pkg::ELEM_W-1:0];
				sat[c] = 1'b0;
			end
		end
	end

	assign overflow = |sat;

endmodule

/* rtl/core/matrix4x4_row_alu.sv */
// Top level of the row-at-a-time 4x4 fixed-point matrix ALU.
//
// Each request on the s_axis channel carries one matrix row and a kind in
// tuser: load a row of the stored right-hand matrix, multiply the row by the
// stored matrix, add or subtract the stored row of the same index, or scale
// the row by scale_factor. Every request except a load or an unknown kind
// gives one result row on m_axis, with the overflow flag in tuser.
// Elements are signed fixed point with FRAC_BITS fraction bits, and results
// saturate to 32 bits.
// The block takes one request per clock cycle while the output is not stalled.
// An accepted request is held in the input register, its products are
// registered in the second stage, and the saturated sums reach the output register.
// A load updates the stored matrix in time for the very next request.
// When the receiver stalls, empty stages keep filling and s_axis_tready falls
// only once all three stages hold data.
// Reset empties the pipeline; the stored matrix is not cleared and a row must
// be loaded before any request reads it.
module matrix4x4_row_alu #(
	parameter int FRAC_BITS = mra_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// row, elem0, elem1, elem2, elem3, scale_factor, zero padding
	input  logic [mra_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// kind
	input  logic [mra_pkg::KIND_W-1:0]       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_row, res0, res1, res2, res3, zero padding
	output logic [mra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// overflow
	output logic                             m_axis_tuser
);

	localparam int NC = mra_pkg::NCOLS;
	localparam int EW = mra_pkg::ELEM_W;
	localparam int RW = mra_pkg::ROW_W;

	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2, valid_s3;

	mra_pkg::kind_t   kind_s1;
	logic [RW-1:0]    row_s1;
	mra_pkg::elem_t   elem_s1 [NC];
	mra_pkg::elem_t   scale_s1;

	mra_pkg::elem_t   mat [mra_pkg::NENTRIES];
	mra_pkg::prod_t   prod   [NC][NC];
	mra_pkg::addsub_t addsub [NC];
	mra_pkg::ctl_t    ctl;
	logic             load_we;

	mra_pkg::prod_t   prod_s2   [NC][NC];
	mra_pkg::addsub_t addsub_s2 [NC];
	mra_pkg::ctl_t    ctl_s2;

	mra_pkg::elem_t   res [NC];
	logic             ovf;
	mra_pkg::elem_t   res_s3 [NC];
	logic [RW-1:0]    row_s3;
	logic             ovf_s3;

	assign en_s3         = !valid_s3 || m_axis_tready;
	assign en_s2         = !valid_s2 || en_s3;
	assign en_s1         = !valid_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1 && ctl.has_result;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			kind_s1  <= mra_pkg::kind_t'(s_axis_tuser);
			row_s1   <= s_axis_tdata[RW-1:0];
			for (int c = 0; c < NC; c++) begin
				elem_s1[c] <= s_axis_tdata[RW + EW * c +: EW];
			end
			scale_s1 <= s_axis_tdata[RW + EW * NC +: EW];
		end
		if (en_s2 && valid_s1) begin
			prod_s2   <= prod;
			addsub_s2 <= addsub;
			ctl_s2    <= ctl;
		end
		if (en_s3 && valid_s2) begin
			res_s3 <= res;
			row_s3 <= ctl_s2.row;
			ovf_s3 <= ovf;
		end
	end

	assign load_we = valid_s1 && en_s2 && (kind_s1 == mra_pkg::KIND_LOAD);

	mra_matrix_store u_store (
		.clk   (clk),
		.we    (load_we),
		.wrow  (row_s1),
		.wdata (elem_s1),
		.mat   (mat)
	);

	mra_product u_product (
		.kind         (kind_s1),
		.row          (row_s1),
		.elem         (elem_s1),
		.scale_factor (scale_s1),
		.mat          (mat),
		.prod         (prod),
		.addsub       (addsub),
		.ctl          (ctl)
	);

	mra_reduce #(
		.FRAC_BITS (FRAC_BITS)
	) u_reduce (
		.prod      (prod_s2),
		.addsub    (addsub_s2),
		.is_addsub (ctl_s2.is_addsub),
		.res       (res),
		.overflow  (ovf)
	);

	always_comb begin
		m_axis_tdata         = '0;
		m_axis_tdata[RW-1:0] = row_s3;
		for (int c = 0; c < NC; c++) begin
			m_axis_tdata[RW + EW * c +: EW] = res_s3[c];
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tuser  = ovf_s3;

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en_s2 && kind_s1 == mra_pkg::KIND_LOAD) |=> !valid_s2)
		else $error("load request produced a result");

	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
		(res_s3[0] == mra_pkg::ELEM_MAX || res_s3[0] == mra_pkg::ELEM_MIN ||
		 res_s3[1] == mra_pkg::ELEM_MAX || res_s3[1] == mra_pkg::ELEM_MIN ||
		 res_s3[2] == mra_pkg::ELEM_MAX || res_s3[2] == mra_pkg::ELEM_MIN ||
		 res_s3[3] == mra_pkg::ELEM_MAX || res_s3[3] == mra_pkg::ELEM_MIN))
		else $error("overflow set without a saturated element");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && !m_axis_tready) |-> !s_axis_tready)
		else $error("request accepted into a full stalled pipeline");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !valid_s2 || !valid_s3) |-> s_axis_tready)
		else $error("ready low while a stage is free");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the matrix4x4_row_alu streaming matrix row ALU.
`timescale 1ns / 100ps

class row_alu_predictor;
	localparam int FRAC = mra_pkg::FRAC_BITS_DEF;
	localparam int WIDE = 66;

	typedef struct {
		logic [mra_pkg::ROW_W-1:0] row;
		mra_pkg::elem_t            res [mra_pkg::NCOLS];
		logic                      overflow;
	} row_result_t;

	mra_pkg::elem_t stored [mra_pkg::NCOLS][mra_pkg::NCOLS];
	row_result_t    expected_rows [$];
	int             mismatches;

	function new();
		mismatches = 0;
		foreach (stored[r, c])
			stored[r][c] = '0;
	endfunction

	function int pending();
		return expected_rows.size();
	endfunction

	task report(input string what);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	function mra_pkg::elem_t clamp(input logic signed [WIDE-1:0] v, inout logic ovf);
		logic signed [WIDE-1:0] hi;
		logic signed [WIDE-1:0] lo;
		hi = mra_pkg::ELEM_MAX;
		lo = mra_pkg::ELEM_MIN;
		if (v > hi) begin
			ovf = 1'b1;
			return mra_pkg::ELEM_MAX;
		end else if (v < lo) begin
			ovf = 1'b1;
			return mra_pkg::ELEM_MIN;
		end
		return mra_pkg::elem_t'(v);
	endfunction

	// Works out the result row of one accepted request, or updates the stored matrix.
	function void note_request(input logic [mra_pkg::KIND_W-1:0] kind,
			input logic [mra_pkg::ROW_W-1:0] row,
			input mra_pkg::elem_t e [mra_pkg::NCOLS], input mra_pkg::elem_t factor);
		row_result_t            expected;
		logic signed [WIDE-1:0] acc;
		logic signed [WIDE-1:0] a;
		logic signed [WIDE-1:0] b;
		expected.row = row;
		expected.overflow = 1'b0;
		case (kind)
			mra_pkg::KIND_LOAD: begin
				for (int c = 0; c < mra_pkg::NCOLS; c++)
					stored[row][c] = e[c];
				return;
			end
			mra_pkg::KIND_MUL, mra_pkg::KIND_ADD, mra_pkg::KIND_SUB,
			mra_pkg::KIND_SCALE: begin
				for (int c = 0; c < mra_pkg::NCOLS; c++) begin
					acc = '0;
					if (kind == mra_pkg::KIND_MUL) begin
						for (int k = 0; k < mra_pkg::NCOLS; k++) begin
							a = e[k];
							b = stored[k][c];
							acc = acc + a * b;
						end
						acc = acc >>> FRAC;
					end else if (kind == mra_pkg::KIND_SCALE) begin
						a = e[c];
						b = factor;
						acc = (a * b) >>> FRAC;
					end else begin
						a = e[c];
						b = stored[row][c];
						acc = (kind == mra_pkg::KIND_ADD) ? a + b : a - b;
					end
					expected.res[c] = clamp(acc, expected.overflow);
				end
				expected_rows.push_back(expected);
			end
			default: return;
		endcase
	endfunction

	task check_result(input logic [mra_pkg::OUT_TDATA_W-1:0] data, input logic ovf);
		row_result_t    expected;
		mra_pkg::elem_t got;
		if (expected_rows.size() == 0) begin
			report($sformatf("result row %0d with no request outstanding", data[1:0]));
			return;
		end
		expected = expected_rows.pop_front();
		if (data[mra_pkg::ROW_W-1:0] !== expected.row)
			report($sformatf("out_row got %0d expected %0d", data[1:0], expected.row));
		for (int c = 0; c < mra_pkg::NCOLS; c++) begin
			got = data[mra_pkg::ROW_W + c * mra_pkg::ELEM_W +: mra_pkg::ELEM_W];
			if (got !== expected.res[c])
				report($sformatf("row %0d res%0d got %h expected %h", expected.row, c, got,
					expected.res[c]));
		end
		if (ovf !== expected.overflow)
			report($sformatf("row %0d overflow got %b expected %b", expected.row, ovf,
				expected.overflow));
	endtask
endclass

module testbench;

	localparam int FRAC = mra_pkg::FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam int RANDOM_REQUESTS = 560;
	localparam logic [mra_pkg::KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [mra_pkg::KIND_W-1:0] KIND_UNUSED_LAST = 3'd7;
	localparam mra_pkg::elem_t ONE = 32'sh0001_0000;
	localparam mra_pkg::elem_t HALF = 32'sh0000_8000;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [mra_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [mra_pkg::KIND_W-1:0]      s_axis_tuser = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [mra_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tuser;

	bit calm = 1'b0;
	bit long_hold = 1'b0;
	int idle_cycles = 0;

	row_alu_predictor predictor = new();

	matrix4x4_row_alu #(.FRAC_BITS(FRAC)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Each call starts and ends at a falling edge.
	task send_request(input logic [mra_pkg::KIND_W-1:0] kind,
			input logic [mra_pkg::ROW_W-1:0] row,
			input mra_pkg::elem_t e0, input mra_pkg::elem_t e1, input mra_pkg::elem_t e2,
			input mra_pkg::elem_t e3, input mra_pkg::elem_t factor);
		mra_pkg::elem_t                 e [mra_pkg::NCOLS];
		logic [mra_pkg::IN_TDATA_W-1:0] packed_req;
		e[0] = e0;
		e[1] = e1;
		e[2] = e2;
		e[3] = e3;
		packed_req = '0;
		packed_req[mra_pkg::ROW_W-1:0] = row;
		for (int c = 0; c < mra_pkg::NCOLS; c++)
			packed_req[mra_pkg::ROW_W + c * mra_pkg::ELEM_W +: mra_pkg::ELEM_W] = e[c];
		packed_req[mra_pkg::ROW_W + mra_pkg::NCOLS * mra_pkg::ELEM_W +: mra_pkg::ELEM_W] =
			factor;
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= packed_req;
		s_axis_tuser <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predictor.note_request(kind, row, e, factor);
		@(negedge clk);
	endtask

	task wait_for_results;
		s_axis_tvalid <= 1'b0;
		while (predictor.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function mra_pkg::elem_t rand_elem();
		case ($urandom_range(0, 9))
			0: return mra_pkg::ELEM_MAX;
			1: return mra_pkg::ELEM_MIN;
			2: return '0;
			3, 4, 5: return mra_pkg::elem_t'(int'($urandom_range(0, 32'h0008_0000)) -
				32'sh0004_0000);
			default: return mra_pkg::elem_t'($urandom);
		endcase
	endfunction

	task send_random;
		logic [mra_pkg::KIND_W-1:0] kind;
		int                         pick;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			kind = mra_pkg::KIND_LOAD;
		else if (pick < 45)
			kind = mra_pkg::KIND_MUL;
		else if (pick < 60)
			kind = mra_pkg::KIND_ADD;
		else if (pick < 75)
			kind = mra_pkg::KIND_SUB;
		else if (pick < 95)
			kind = mra_pkg::KIND_SCALE;
		else
			kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
		send_request(kind, 2'($urandom), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
			rand_elem());
	endtask

	always begin
		if (long_hold) begin
			m_axis_tready <= 1'b0;
			repeat (LONG_HOLD) @(negedge clk);
			long_hold = 1'b0;
		end else if (!calm && arst_n && $urandom_range(0, 9) == 0) begin
			m_axis_tready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end else begin
			m_axis_tready <= 1'b1;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			predictor.check_result(m_axis_tdata, m_axis_tuser);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("matrix4x4_row_alu regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every stored row is loaded before anything reads the matrix.
		send_request(mra_pkg::KIND_LOAD, 2'd0, mra_pkg::ELEM_MAX, mra_pkg::ELEM_MIN, '0,
			32'sd1, '0);
		send_request(mra_pkg::KIND_LOAD, 2'd1, ONE, -32'sd1, mra_pkg::ELEM_MAX,
			mra_pkg::ELEM_MIN, '0);
		send_request(mra_pkg::KIND_LOAD, 2'd2, '0, ONE, -ONE, HALF, '0);
		send_request(mra_pkg::KIND_LOAD, 2'd3, mra_pkg::ELEM_MIN, mra_pkg::ELEM_MAX, ONE,
			'0, '0);

		send_request(mra_pkg::KIND_MUL, 2'd0, ONE, '0, '0, '0, '0);
		send_request(mra_pkg::KIND_MUL, 2'd1, mra_pkg::ELEM_MIN, mra_pkg::ELEM_MIN,
			mra_pkg::ELEM_MIN, mra_pkg::ELEM_MIN, '0);
		send_request(mra_pkg::KIND_MUL, 2'd2, -32'sd1, -32'sd1, -32'sd1, -32'sd1, '0);
		send_request(mra_pkg::KIND_MUL, 2'd3, mra_pkg::ELEM_MAX, mra_pkg::ELEM_MAX,
			mra_pkg::ELEM_MAX, mra_pkg::ELEM_MAX, mra_pkg::ELEM_MAX);
		send_request(mra_pkg::KIND_ADD, 2'd0, mra_pkg::ELEM_MAX, mra_pkg::ELEM_MIN, '0,
			-32'sd1, '0);
		send_request(mra_pkg::KIND_SUB, 2'd1, mra_pkg::ELEM_MIN, mra_pkg::ELEM_MAX, '0, '0,
			'0);
		send_request(mra_pkg::KIND_SCALE, 2'd2, mra_pkg::ELEM_MIN, mra_pkg::ELEM_MAX,
			-32'sd1, 32'sd1, mra_pkg::ELEM_MIN);
		send_request(mra_pkg::KIND_SCALE, 2'd3, ONE, -ONE, HALF, -HALF, HALF);
		send_request(mra_pkg::KIND_SCALE, 2'd0, -32'sd1, 32'sd1, -32'sd1, mra_pkg::ELEM_MAX,
			32'sd1);
		for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
			send_request(3'(k), 2'(k), mra_pkg::ELEM_MAX, mra_pkg::ELEM_MIN, ONE, -ONE,
				mra_pkg::ELEM_MAX);

		// A load whose next request reads the new row; a random gap may come between them.
		send_request(mra_pkg::KIND_LOAD, 2'd2, mra_pkg::ELEM_MAX, mra_pkg::ELEM_MAX,
			mra_pkg::ELEM_MAX, mra_pkg::ELEM_MAX, '0);
		send_request(mra_pkg::KIND_MUL, 2'd2, '0, '0, ONE, '0, '0);
		send_request(mra_pkg::KIND_ADD, 2'd2, mra_pkg::ELEM_MIN, '0, mra_pkg::ELEM_MAX, ONE,
			'0);
		send_request(mra_pkg::KIND_SUB, 2'd3, '0, '0, '0, '0, '0);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == 150)
				long_hold = 1'b1;
			if (n == 300)
				wait_for_results();
			if (n == 460)
				calm = 1'b1;
			send_random();
		end

		s_axis_tvalid <= 1'b0;
		while (predictor.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (predictor.mismatches == 0)
			$display("matrix4x4_row_alu regression: pass");
		else
			$display("matrix4x4_row_alu regression: fail");
		$finish;
	end
endmodule
